[sv/rotation_matrix_to_quaternion_assert.svh]
// Assertion macros for the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`ifndef ASSERT_OFF
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RMQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RMQ_ASSERT(lbl, prop, msg)
`define RMQ_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[sv/rmq_pkg.sv]
package rmq_pkg;

  localparam int DW   = 16;
  localparam int FB   = 14;
  localparam int EW   = DW + 3;
  localparam int RW   = DW + 2;
  localparam int SQW  = ((RW + FB - 2 + 1) / 2) * 2;
  localparam int HW   = SQW / 2;
  localparam int RMW  = HW + 2;
  localparam int MW   = DW + 1;
  localparam int NUMW = MW + FB + 1;
  localparam int DENW = HW + 2;
  localparam int NL   = 4;
  localparam int SLW  = 2;

  typedef struct packed {
    logic [SQW-1:0]         rad;
    logic [RMW-1:0]         rem;
    logic [HW-1:0]          root;
    logic [NL-1:0][MW-1:0]  mag;
    logic [NL-1:0]          neg;
    logic [SLW-1:0]         slot;
    logic                   degen;
  } sq_t;

  typedef struct packed {
    logic [NL-1:0][NUMW-1:0] num;
    logic [NL-1:0][DENW-1:0] rem;
    logic [NL-1:0][NUMW-1:0] quot;
    logic [DENW-1:0]         den;
    logic [HW-1:0]           root;
    logic [NL-1:0]           neg;
    logic [SLW-1:0]          slot;
    logic                    degen;
  } dv_t;

  typedef struct packed {
    logic [NL-1:0][DW-1:0] q;
    logic                  degen;
  } res_t;

  function automatic logic [1:0] nxt(logic [1:0] a);
    logic [1:0] r;
    unique case (a)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DW-1:0] sat(logic [NUMW-1:0] mag, logic neg);
    logic [NUMW-1:0] lim;
    logic [NUMW-1:0] m;
    lim = NUMW'(1) << (DW - 1);
    if (neg) begin
      m = (mag > lim) ? lim : mag;
      m = ~m + NUMW'(1);
    end else begin
      m = (mag > lim - NUMW'(1)) ? lim - NUMW'(1) : mag;
    end
    return m[DW-1:0];
  endfunction

endpackage

[sv/rmq_sqrt_cell.sv]
module rmq_sqrt_cell import rmq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  sq_t  data_i,
  output logic valid_o,
  output sq_t  data_o
);

  logic [RMW+1:0] rem_w;
  logic [RMW+1:0] trial;
  sq_t            data_d;
  sq_t            data_q;
  logic           valid_q;

  always_comb begin
    data_d     = data_i;
    rem_w      = {data_i.rem, data_i.rad[SQW-1 -: 2]};
    trial      = (RMW+2)'({data_i.root, 2'b01});
    data_d.rad = {data_i.rad[SQW-3:0], 2'b00};
    if (rem_w >= trial) begin
      data_d.rem  = RMW'(rem_w - trial);
      data_d.root = {data_i.root[HW-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_w[RMW-1:0];
      data_d.root = {data_i.root[HW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/rmq_div_cell.sv]
module rmq_div_cell import rmq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  dv_t  data_i,
  output logic valid_o,
  output dv_t  data_o
);

  logic [DENW:0] r2 [NL];
  logic [NL-1:0] ge;
  dv_t           data_d;
  dv_t           data_q;
  logic          valid_q;

  always_comb begin
    data_d = data_i;
    for (int l = 0; l < NL; l++) begin
      r2[l] = {data_i.rem[l], data_i.num[l][NUMW-1]};
      ge[l] = r2[l] >= {1'b0, data_i.den};
      data_d.rem[l]  = ge[l] ? DENW'(r2[l] - {1'b0, data_i.den}) : r2[l][DENW-1:0];
      data_d.quot[l] = {data_i.quot[l][NUMW-2:0], ge[l]};
      data_d.num[l]  = {data_i.num[l][NUMW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/rotation_matrix_to_quaternion.sv]
// Stages from input beat to output valid: 1 front stage, 15 square root cells, 1 setup
// stage, 32 divider cells, 1 output register.
// Throughput: one beat per cycle unless the skid register is full; the divider cell chain makes up most of the depth.
// A skid register behind the output takes one result while the output is held.
// Reset (rst_ni low, asynchronous) clears all valid bits; no beat is in flight.
`include "rotation_matrix_to_quaternion_assert.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [DW-1:0] m00_i,
  input  logic signed [DW-1:0] m01_i,
  input  logic signed [DW-1:0] m02_i,
  input  logic signed [DW-1:0] m10_i,
  input  logic signed [DW-1:0] m11_i,
  input  logic signed [DW-1:0] m12_i,
  input  logic signed [DW-1:0] m20_i,
  input  logic signed [DW-1:0] m21_i,
  input  logic signed [DW-1:0] m22_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [DW-1:0] qw_o,
  output logic signed [DW-1:0] qx_o,
  output logic signed [DW-1:0] qy_o,
  output logic signed [DW-1:0] qz_o,
  output logic                 degenerate_o
);

  localparam logic signed [EW-1:0] ONE = EW'(1) << FB;

  logic                 en;
  logic signed [DW-1:0] m [3][3];
  logic signed [EW-1:0] tr;
  logic signed [EW-1:0] rr;
  logic signed [MW-1:0] d [NL];
  logic [1:0]           ax_i0;
  logic [1:0]           ax_i;
  logic [1:0]           ax_j;
  logic [1:0]           ax_k;
  logic                 pos;
  sq_t                  fr_d;
  sq_t                  fr_q;
  logic                 fr_v_q;

  sq_t                  sq_x [HW+1];
  logic                 sq_v [HW+1];
  dv_t                  cv_d;
  dv_t                  cv_q;
  logic                 cv_v_q;
  dv_t                  dv_x [NUMW+1];
  logic                 dv_v [NUMW+1];

  res_t                 res;
  res_t                 out_q;
  res_t                 skid_q;
  logic                 out_v_q;
  logic                 skid_v_q;
  logic                 out_free;

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign out_free   = !out_v_q || out_ready_i;

  assign m[0][0] = m00_i;
  assign m[0][1] = m01_i;
  assign m[0][2] = m02_i;
  assign m[1][0] = m10_i;
  assign m[1][1] = m11_i;
  assign m[1][2] = m12_i;
  assign m[2][0] = m20_i;
  assign m[2][1] = m21_i;
  assign m[2][2] = m22_i;

  always_comb begin
    tr    = EW'(m[0][0]) + EW'(m[1][1]) + EW'(m[2][2]);
    pos   = tr > 0;
    ax_i0 = (m[1][1] > m[0][0]) ? 2'd1 : 2'd0;
    ax_i  = (m[2][2] > m[ax_i0][ax_i0]) ? 2'd2 : ax_i0;
    ax_j  = nxt(ax_i);
    ax_k  = nxt(ax_j);
    for (int l = 0; l < NL; l++) begin
      d[l] = '0;
    end
    if (pos) begin
      rr   = tr + ONE;
      d[1] = MW'(m[2][1]) - MW'(m[1][2]);
      d[2] = MW'(m[0][2]) - MW'(m[2][0]);
      d[3] = MW'(m[1][0]) - MW'(m[0][1]);
      fr_d.slot = '0;
    end else begin
      rr = EW'(m[ax_i][ax_i]) - EW'(m[ax_j][ax_j]) - EW'(m[ax_k][ax_k]) + ONE;
      d[0]        = MW'(m[ax_k][ax_j]) - MW'(m[ax_j][ax_k]);
      d[ax_j + 1] = MW'(m[ax_j][ax_i]) + MW'(m[ax_i][ax_j]);
      d[ax_k + 1] = MW'(m[ax_k][ax_i]) + MW'(m[ax_i][ax_k]);
      fr_d.slot   = SLW'(ax_i) + SLW'(1);
    end
    fr_d.degen = !pos && (rr <= 0);
    fr_d.rad   = fr_d.degen ? '0 : SQW'(rr[RW-1:0]) << (FB - 2);
    fr_d.rem   = '0;
    fr_d.root  = '0;
    for (int l = 0; l < NL; l++) begin
      fr_d.neg[l] = d[l][MW-1];
      fr_d.mag[l] = d[l][MW-1] ? MW'(-d[l]) : MW'(d[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
      cv_v_q <= 1'b0;
    end else if (en) begin
      fr_v_q <= in_valid_i;
      cv_v_q <= sq_v[HW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr_q <= fr_d;
      cv_q <= cv_d;
    end
  end

  assign sq_x[0] = fr_q;
  assign sq_v[0] = fr_v_q;

  for (genvar g = 0; g < HW; g++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[g]),
      .data_i  (sq_x[g]),
      .valid_o (sq_v[g+1]),
      .data_o  (sq_x[g+1])
    );
  end

  always_comb begin
    cv_d.root  = sq_x[HW].root;
    cv_d.den   = {sq_x[HW].root, 2'b00};
    cv_d.neg   = sq_x[HW].neg;
    cv_d.slot  = sq_x[HW].slot;
    cv_d.degen = sq_x[HW].degen;
    for (int l = 0; l < NL; l++) begin
      cv_d.num[l]  = (NUMW'(sq_x[HW].mag[l]) << FB) + NUMW'({sq_x[HW].root, 1'b0});
      cv_d.rem[l]  = '0;
      cv_d.quot[l] = '0;
    end
  end

  assign dv_x[0] = cv_q;
  assign dv_v[0] = cv_v_q;

  for (genvar g = 0; g < NUMW; g++) begin : g_div
    rmq_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[g]),
      .data_i  (dv_x[g]),
      .valid_o (dv_v[g+1]),
      .data_o  (dv_x[g+1])
    );
  end

  always_comb begin
    res.degen = dv_x[NUMW].degen;
    for (int l = 0; l < NL; l++) begin
      if (dv_x[NUMW].degen) begin
        res.q[l] = '0;
      end else if (SLW'(l) == dv_x[NUMW].slot) begin
        res.q[l] = sat(NUMW'(dv_x[NUMW].root), 1'b0);
      end else begin
        res.q[l] = sat(dv_x[NUMW].quot[l], dv_x[NUMW].neg[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= dv_v[NUMW];
      end
    end else if (dv_v[NUMW]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (en) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_v_q;
  assign qw_o         = out_q.q[0];
  assign qx_o         = out_q.q[1];
  assign qy_o         = out_q.q[2];
  assign qz_o         = out_q.q[3];
  assign degenerate_o = out_q.degen;

  `RMQ_ASSERT(a_degen_zero, out_valid_o && degenerate_o |-> qw_o == 0 && qx_o == 0 && qy_o == 0 && qz_o == 0, "degenerate result with nonzero parts")
  `RMQ_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid holds a beat while output empty")
  `RMQ_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o && !skid_v_q, "beat present during reset")

endmodule

[dv/rotation_matrix_to_quaternion_test.sv]
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 1 << FB;
  localparam int LATENCY = 50;

  typedef struct packed {
    logic signed [DW-1:0] w;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic                 degen;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [DW-1:0] m_i [3][3];
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DW-1:0] qw_o, qx_o, qy_o, qz_o;
  logic degenerate_o;

  quat_t expected_quats[$];
  int errors = 0;
  bit stall_enable = 1'b1;

  initial begin
    for (int a = 0; a < 3; a++) for (int b = 0; b < 3; b++) m_i[a][b] = '0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rotation_matrix_to_quaternion i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .m00_i(m_i[0][0]), .m01_i(m_i[0][1]), .m02_i(m_i[0][2]),
    .m10_i(m_i[1][0]), .m11_i(m_i[1][1]), .m12_i(m_i[1][2]),
    .m20_i(m_i[2][0]), .m21_i(m_i[2][1]), .m22_i(m_i[2][2]),
    .out_valid_o, .out_ready_i,
    .qw_o, .qx_o, .qy_o, .qz_o, .degenerate_o
  );

  function automatic longint unsigned half_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] clamp(longint unsigned mag, bit neg);
    longint unsigned lim;
    lim = 64'd1 << (DW - 1);
    if (neg) begin
      if (mag > lim) mag = lim;
      return DW'(-longint'(mag));
    end
    if (mag > lim - 1) mag = lim - 1;
    return DW'(mag);
  endfunction

  function automatic logic [DW-1:0] part_div(longint d, longint unsigned den);
    bit neg;
    longint unsigned mag;
    neg = d < 0;
    mag = neg ? longint'(-d) : longint'(d);
    return clamp(((mag << FB) + den / 2) / den, neg);
  endfunction

  function automatic quat_t matrix_to_quat(logic signed [DW-1:0] mm [3][3]);
    longint m [3][3];
    logic [DW-1:0] qo [4];
    longint tr, r;
    longint unsigned h;
    int i, j, k;
    quat_t res;
    for (int a = 0; a < 3; a++) for (int b = 0; b < 3; b++) m[a][b] = longint'(mm[a][b]);
    res = '0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      h = half_root(longint'(tr + ONE) << (FB - 2));
      res.w = clamp(h, 1'b0);
      res.x = part_div(m[2][1] - m[1][2], 4 * h);
      res.y = part_div(m[0][2] - m[2][0], 4 * h);
      res.z = part_div(m[1][0] - m[0][1], 4 * h);
      return res;
    end
    i = 0;
    if (m[1][1] > m[0][0]) i = 1;
    if (m[2][2] > m[i][i]) i = 2;
    j = (i + 1) % 3;
    k = (j + 1) % 3;
    r = m[i][i] - m[j][j] - m[k][k] + ONE;
    if (r <= 0) begin
      res.degen = 1'b1;
      return res;
    end
    h = half_root(longint'(r) << (FB - 2));
    if (h == 0) begin
      res.degen = 1'b1;
      return res;
    end
    qo[1 + i] = clamp(h, 1'b0);
    qo[0] = part_div(m[k][j] - m[j][k], 4 * h);
    qo[1 + j] = part_div(m[j][i] + m[i][j], 4 * h);
    qo[1 + k] = part_div(m[k][i] + m[i][k], 4 * h);
    res.w = qo[0];
    res.x = qo[1];
    res.y = qo[2];
    res.z = qo[3];
    return res;
  endfunction

  function automatic int gap_len();
    if (!stall_enable || $urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_matrix(logic signed [DW-1:0] mm [3][3]);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    m_i = mm;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_quats.push_back(matrix_to_quat(mm));
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_ready_i <= (gap_len() == 0);

  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {qw_o, qx_o, qy_o, qz_o, degenerate_o};
      if (expected_quats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = expected_quats.pop_front();
        if (got.w !== want.w) begin $error("qw exp %0d got %0d", want.w, got.w); errors++; end
        if (got.x !== want.x) begin $error("qx exp %0d got %0d", want.x, got.x); errors++; end
        if (got.y !== want.y) begin $error("qy exp %0d got %0d", want.y, got.y); errors++; end
        if (got.z !== want.z) begin $error("qz exp %0d got %0d", want.z, got.z); errors++; end
        if (got.degen !== want.degen) begin
          $error("degenerate exp %0d got %0d", want.degen, got.degen);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [DW-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return DW'($urandom());
      1: return DW'(ONE - int'($urandom_range(0, 8)));
      2: return DW'(int'($urandom_range(0, 8)) - ONE);
      3: return DW'(int'($urandom_range(0, 2 * ONE)) - ONE);
      4: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return DW'(int'($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  // Random entries in [-1, 1], some set near +1 or -1; the common case.
  task automatic send_rotation_like();
    logic signed [DW-1:0] mm [3][3];
    int perm, s;
    perm = $urandom_range(0, 2);
    for (int a = 0; a < 3; a++) for (int b = 0; b < 3; b++) begin
      mm[a][b] = DW'(int'($urandom_range(0, 2 * ONE)) - ONE);
      if ($urandom_range(0, 1)) mm[a][b] = mm[a][b] >>> $urandom_range(0, 8);
    end
    for (int a = 0; a < 3; a++) begin
      s = $urandom_range(0, 1) ? ONE : -ONE;
      if ($urandom_range(0, 1)) mm[a][(a + perm) % 3] = DW'(s - int'($urandom_range(0, 200)));
    end
    send_matrix(mm);
  endtask

  task automatic test_directed();
    logic signed [DW-1:0] mm [3][3];
    for (int n = 0; n < 14; n++) begin
      for (int a = 0; a < 3; a++) for (int b = 0; b < 3; b++) mm[a][b] = '0;
      case (n)
        0: begin mm[0][0] = DW'(ONE); mm[1][1] = DW'(ONE); mm[2][2] = DW'(ONE); end
        1: begin mm[0][0] = DW'(ONE); mm[1][1] = DW'(-ONE); mm[2][2] = DW'(-ONE); end
        2: begin mm[0][0] = DW'(-ONE); mm[1][1] = DW'(ONE); mm[2][2] = DW'(-ONE); end
        3: begin mm[0][0] = DW'(-ONE); mm[1][1] = DW'(-ONE); mm[2][2] = DW'(ONE); end
        4: ;
        5: begin mm[0][0] = DW'(-ONE); mm[1][1] = DW'(-ONE); mm[2][2] = DW'(-ONE); end
        6: for (int a = 0; a < 3; a++) for (int b = 0; b < 3; b++) mm[a][b] = 16'sh7fff;
        7: for (int a = 0; a < 3; a++) for (int b = 0; b < 3; b++) mm[a][b] = 16'sh8000;
        8: begin
          mm[0][0] = DW'(-ONE); mm[1][1] = DW'(-ONE); mm[2][2] = DW'(-ONE);
          mm[0][1] = 16'sh7fff; mm[1][0] = 16'sh7fff; mm[0][2] = 16'sh8000;
          mm[2][0] = 16'sh8000; mm[1][2] = 16'sh7fff; mm[2][1] = 16'sh8000;
        end
        9: begin mm[0][0] = 16'sd1; mm[1][1] = '0; mm[2][2] = -16'sd1; mm[2][1] = 16'sh7fff; end
        10: begin mm[0][0] = -16'sd100; mm[1][1] = -16'sd100; mm[2][2] = -16'sd100; end
        11: begin mm[0][0] = DW'(-ONE); mm[1][1] = DW'(-ONE); mm[2][2] = 16'sh8000; end
        12: begin mm[0][0] = 16'sh8000; mm[1][1] = 16'sh8000; mm[2][2] = 16'sh8000; end
        default: begin mm[0][1] = DW'(-ONE); mm[1][0] = DW'(ONE); mm[2][2] = DW'(ONE); end
      endcase
      send_matrix(mm);
    end
  endtask

  task automatic test_random();
    logic signed [DW-1:0] mm [3][3];
    for (int n = 0; n < 800; n++) begin
      stall_enable = (n % 200) >= 40;
      if ($urandom_range(0, 3) != 0) begin
        send_rotation_like();
      end else begin
        for (int a = 0; a < 3; a++) for (int b = 0; b < 3; b++) mm[a][b] = rand_elem();
        send_matrix(mm);
      end
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    in_valid_i <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[rotation_matrix_to_quaternion.f]
+incdir+sv
sv/rmq_pkg.sv
sv/rmq_sqrt_cell.sv
sv/rmq_div_cell.sv
sv/rotation_matrix_to_quaternion.sv
dv/rotation_matrix_to_quaternion_test.sv
